### sv/dgt_pkg.sv
// dgt_pkg: shared types, sizes and codes of the depth grid triangulator
`timescale 1ns / 1ps

package dgt_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;
    localparam int NUM_W      = 20;
    localparam int COORD_W    = 32;
    localparam int COLOR_W    = 8;
    localparam int ENTRY_W    = NUM_W + 1;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef enum logic [0:0] {
        CFG_MAP_WIDTH  = 1'b0,
        CFG_MAP_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [COLOR_W-1:0]        tex_blue;
        logic [COLOR_W-1:0]        tex_green;
        logic [COLOR_W-1:0]        tex_red;
    } t_pixel;

    typedef struct packed {
        logic                      result_kind;
        logic [NUM_W-1:0]          index_a;
        logic [NUM_W-1:0]          index_b;
        logic [NUM_W-1:0]          index_c;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [COLOR_W-1:0]        color_red;
        logic [COLOR_W-1:0]        color_green;
        logic [COLOR_W-1:0]        color_blue;
        logic                      run_last;
    } t_result;

    // one classified valid pixel, as it waits between front and back
    typedef struct packed {
        logic                      quad;
        logic [NUM_W-1:0]          num;
        logic [NUM_W-1:0]          ul_num;
        logic [NUM_W-1:0]          up_num;
        logic [NUM_W-1:0]          left_num;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
    } t_job;

endpackage

### sv/dgt_front.sv
// dgt_front: raster counters, previous-row store and quad classification
`timescale 1ns / 1ps

module dgt_front
    import dgt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  t_pixel           i_pixel,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    output logic             o_q_push,
    output t_job             o_job,
    input  logic             i_q_full
);

    typedef struct packed {
        logic                      valid;
        logic                      left_ok;
        logic                      up_ok;
        logic                      ul_ok;
        logic [NUM_W-1:0]          num;
        logic [NUM_W-1:0]          left_num;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
    } t_stage;

    logic [ENTRY_W-1:0] r_store [MAX_WIDTH];
    logic [ENTRY_W-1:0] r_up_raw;
    logic [ENTRY_W-1:0] r_ul;
    logic               r_s1_vld;
    t_stage             r_s1;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [NUM_W-1:0]   r_vcnt;
    logic               r_left_valid;
    logic [NUM_W-1:0]   r_left_num;

    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic [NUM_W-1:0]   n_vcnt;
    logic               s1_leave;
    logic               accept;
    logic               pix_valid;
    logic               col_last;
    logic               row_last;
    logic [ENTRY_W-1:0] entry;
    t_stage             s1_new;

    assign s1_leave  = r_s1_vld && (!r_s1.valid || !i_q_full);
    assign o_full    = r_s1_vld && !s1_leave;
    assign accept    = i_push && !o_full;
    assign pix_valid = (i_pixel.point_x != '0) || (i_pixel.point_y != '0)
                    || (i_pixel.point_z != '0);
    assign entry     = pix_valid ? {1'b1, r_vcnt} : '0;

    assign col_last = (DIM_W'({1'b0, r_col}) + DIM_W'(1)) >= i_width;
    assign row_last = (DIM_W'({1'b0, r_row}) + DIM_W'(1)) >= i_height;

    always_comb begin
        n_col  = r_col + COL_W'(1);
        n_row  = r_row;
        n_vcnt = pix_valid ? r_vcnt + NUM_W'(1) : r_vcnt;
        if (col_last) begin
            n_col = '0;
            if (row_last) begin
                n_row  = '0;
                n_vcnt = '0;
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end
    end

    always_comb begin
        s1_new.valid    = pix_valid;
        s1_new.left_ok  = (r_col != '0) && r_left_valid;
        s1_new.up_ok    = (r_row != '0);
        s1_new.ul_ok    = (r_row != '0) && (r_col != '0);
        s1_new.num      = r_vcnt;
        s1_new.left_num = r_left_num;
        s1_new.x        = i_pixel.point_x;
        s1_new.y        = i_pixel.point_y;
        s1_new.z        = i_pixel.point_z;
        s1_new.red      = i_pixel.tex_red;
        s1_new.green    = i_pixel.tex_green;
        s1_new.blue     = i_pixel.tex_blue;
    end

    // read-first: the pixel sees the entry its column held one row ago
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_raw       <= r_store[r_col];
            r_store[r_col] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= s1_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_vcnt       <= '0;
            r_left_valid <= 1'b0;
            r_left_num   <= '0;
            r_ul         <= '0;
        end else begin
            if (accept) begin
                r_s1_vld     <= 1'b1;
                r_col        <= n_col;
                r_row        <= n_row;
                r_vcnt       <= n_vcnt;
                r_left_valid <= pix_valid;
                r_left_num   <= pix_valid ? r_vcnt : '0;
            end else if (s1_leave) begin
                r_s1_vld <= 1'b0;
            end
            // the old entry of this column is the upper-left of the next pixel
            if (s1_leave) begin
                r_ul <= r_up_raw;
            end
        end
    end

    assign o_q_push = s1_leave && r_s1.valid;

    always_comb begin
        o_job.quad     = r_s1.left_ok && r_s1.up_ok && r_up_raw[NUM_W]
                      && r_s1.ul_ok && r_ul[NUM_W];
        o_job.num      = r_s1.num;
        o_job.ul_num   = r_ul[NUM_W-1:0];
        o_job.up_num   = r_up_raw[NUM_W-1:0];
        o_job.left_num = r_s1.left_num;
        o_job.x        = r_s1.x;
        o_job.y        = r_s1.y;
        o_job.z        = r_s1.z;
        o_job.red      = r_s1.red;
        o_job.green    = r_s1.green;
        o_job.blue     = r_s1.blue;
    end

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && col_last) |=> (r_col == '0))
        else $error("column counter did not wrap at end of row");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && col_last && row_last) |=> (r_row == '0 && r_vcnt == '0))
        else $error("row or vertex counter did not restart at end of frame");

endmodule

### sv/dgt_queue.sv
// dgt_queue: short queue of classified pixels between front and back
`timescale 1ns / 1ps

module dgt_queue
    import dgt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request written into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("request taken from an empty queue");

endmodule

### sv/dgt_back.sv
// dgt_back: expands each queued pixel into its vertex and triangle records
`timescale 1ns / 1ps

module dgt_back
    import dgt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_job    i_job,
    output logic    o_q_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    typedef enum logic [2:0] {
        PH_VERTEX = 3'b001,
        PH_TRI_A  = 3'b010,
        PH_TRI_B  = 3'b100
    } t_phase;

    t_phase  r_phase;
    t_phase  n_phase;
    logic    r_out_vld;
    t_result r_out;
    t_result n_out;
    logic    load;
    logic    job_done;

    assign load = !i_q_empty && (!r_out_vld || i_pop);

    always_comb begin
        n_out          = '0;
        n_phase        = r_phase;
        job_done       = 1'b0;
        unique case (r_phase)
            PH_VERTEX: begin
                n_out.result_kind = KIND_VERTEX;
                n_out.index_a     = i_job.num;
                n_out.out_x       = i_job.x;
                n_out.out_y       = i_job.y;
                n_out.out_z       = i_job.z;
                n_out.color_red   = i_job.red;
                n_out.color_green = i_job.green;
                n_out.color_blue  = i_job.blue;
                n_out.run_last    = !i_job.quad;
                job_done          = !i_job.quad;
                n_phase           = i_job.quad ? PH_TRI_A : PH_VERTEX;
            end
            PH_TRI_A: begin
                // upper-left, current, upper
                n_out.result_kind = KIND_TRIANGLE;
                n_out.index_a     = i_job.ul_num;
                n_out.index_b     = i_job.num;
                n_out.index_c     = i_job.up_num;
                n_phase           = PH_TRI_B;
            end
            PH_TRI_B: begin
                // upper-left, left, current
                n_out.result_kind = KIND_TRIANGLE;
                n_out.index_a     = i_job.ul_num;
                n_out.index_b     = i_job.left_num;
                n_out.index_c     = i_job.num;
                n_out.run_last    = 1'b1;
                job_done          = 1'b1;
                n_phase           = PH_VERTEX;
            end
            default: begin
                n_phase = PH_VERTEX;
            end
        endcase
    end

    assign o_q_pop  = load && job_done;
    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_VERTEX;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_phase   <= n_phase;
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    a_tri_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && r_out_vld && !r_out.run_last)
            |=> (r_out_vld && r_out.result_kind == KIND_TRIANGLE))
        else $error("pixel run broken before its last record");

    a_mid_run_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_VERTEX) |-> !i_q_empty)
        else $error("queue head left while its records were still going out");

endmodule

### sv/depth_grid_triangulator.sv
// depth_grid_triangulator: point map to interleaved vertex and triangle records
//
//   channel   direction  handshake                 payload
//   pixel     in         i_push / o_full           i_pixel  (t_pixel)
//   record    out        o_empty / i_pop           o_result (t_result)
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a pixel is taken every cycle while o_full is low; it yields no record, one vertex,
// or a vertex and two triangles, and the record port moves one per cycle while i_pop
// is high, so the back-end sequencer holds a full quad at the queue head until its
// three records are out. the first record passes the stage register, the queue slot
// and then the output register. reset is synchronous; the row store is not cleared.
// the front and back stall independently through a four-entry queue.
`timescale 1ns / 1ps

module depth_grid_triangulator
    import dgt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  t_pixel           i_pixel,
    output logic             o_empty,
    input  logic             i_pop,
    output t_result          o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [DIM_W-1:0] i_cfg_data
);

    logic [DIM_W-1:0] r_map_width;
    logic [DIM_W-1:0] r_map_height;
    logic [DIM_W-1:0] eff_width;
    logic [DIM_W-1:0] eff_height;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    t_job             front_job;
    t_job             head_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= DIM_W'(640);
            r_map_height <= DIM_W'(480);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturate to the range the store and counters can serve
    always_comb begin
        priority if (r_map_width < DIM_W'(2)) begin
            eff_width = DIM_W'(2);
        end else if (r_map_width > DIM_W'(MAX_WIDTH)) begin
            eff_width = DIM_W'(MAX_WIDTH);
        end else begin
            eff_width = r_map_width;
        end
        priority if (r_map_height < DIM_W'(2)) begin
            eff_height = DIM_W'(2);
        end else if (r_map_height > DIM_W'(MAX_HEIGHT)) begin
            eff_height = DIM_W'(MAX_HEIGHT);
        end else begin
            eff_height = r_map_height;
        end
    end

    dgt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_pixel  (i_pixel),
        .i_width  (eff_width),
        .i_height (eff_height),
        .o_q_push (q_push),
        .o_job    (front_job),
        .i_q_full (q_full)
    );

    dgt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    dgt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (o_result)
    );

endmodule
